### hdl/assert_macros.svh
// assertion macros shared by the rtl files
// clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_HOLDS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### hdl/acsi_pkg.sv
// constants and types for the csi terminal parser
// no dependencies
`timescale 1ns / 1ps
package acsi_pkg;
    localparam int COLS      = 42;
    localparam int ROWS      = 24;
    localparam int ARG_SLOTS = 8;
    localparam int TAB_STEP  = 4;

    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLS);
    localparam int AIDX_W = $clog2(ARG_SLOTS + 1);
    localparam int SLOT_W = $clog2(ARG_SLOTS);
    localparam int TDATA_W = 40;

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_CSI   = 8'h9b;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_FIN_LO = 8'h40;
    localparam logic [7:0] CH_FIN_HI = 8'h7e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_J     = 8'h4a;
    localparam logic [7:0] CH_M     = 8'h6d;

    typedef enum logic [1:0] {
        KIND_GLYPH  = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } t_phase;

    localparam int CFG_FG = 0;
    localparam int CFG_BG = 1;
endpackage

### hdl/ansi_csi_terminal_parser.sv
// csi escape sequence parser with cursor and color tracking
// depends on acsi_pkg and assert_macros.svh
//
// usage: text bytes enter on s_axis (tdata = text_byte), one at a time;
// s_axis_tready is high only while the parser waits for a byte. results
// leave on m_axis: tuser = event kind, tlast = last result of the byte,
// tdata = glyph, row, col, fg, bg. config writes arrive on i_cfg_* and
// are always ready; they change only the default colors.
// timing: a byte that causes no result passes the accept and decode steps.
// a result adds an emit step, held while the receiver stalls tready; the
// output register holds the result until it is taken, and no new byte is
// accepted meanwhile. a glyph at the end of the screen gives a scroll
// transfer then a glyph transfer. an sgr final byte walks the stored
// arguments through the argument memory (one write port, one read port),
// with a read step then an apply step per argument.
// reset: synchronous active low; cursor at top left, parser idle, colors
// 7 on 0. no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ansi_csi_terminal_parser
    import acsi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] text_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // glyph_code, screen_row, screen_col,
                                               // fg_index, bg_index, zero pad
    output logic [1:0]         m_axis_tuser,   // [1:0] event_kind
    output logic               m_axis_tlast,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_SGR_RD, S_SGR_AP, S_EMIT
    } t_state;
    typedef enum logic [2:0] {
        M_PLAIN, M_FG, M_FG5, M_BG, M_BG5
    } t_mode;

    t_state r_state;
    t_phase r_phase;
    t_mode  r_mode;
    logic [7:0]        r_byte, r_dfg, r_dbg, r_fg, r_bg;
    logic [AIDX_W-1:0] r_aidx, r_walk, r_nargs;
    logic [15:0]       r_acc, r_a0, r_rdata;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic              r_pend;
    t_kind             r_okind;
    logic [7:0]        r_oglyph;
    logic [4:0]        r_orow;
    logic [5:0]        r_ocol;
    logic              r_olast;
    logic [15:0]       mem [ARG_SLOTS];

    logic              w_we;
    logic [15:0]       w_a0;
    logic [19:0]       w_dig;
    logic [15:0]       w_digsat;
    logic signed [18:0] w_rsum_up, w_rsum_dn, w_csum_up, w_csum_dn;
    logic [ROW_W-1:0]  w_row_up, w_row_dn, w_cup_row, w_row_base;
    logic [COL_W-1:0]  w_col_up, w_col_dn, w_cup_col;
    logic [COL_W+4:0]  w_tab_nc;
    logic              w_final, w_at_end, w_can_store;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_EMIT);
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {5'b0, r_bg, r_fg, r_ocol, r_orow, r_oglyph};
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        w_final     = (r_byte >= CH_FIN_LO) && (r_byte <= CH_FIN_HI);
        w_can_store = (r_aidx < AIDX_W'(ARG_SLOTS));
        w_at_end    = (r_row == ROW_W'(ROWS));
        w_row_base  = w_at_end ? ROW_W'(ROWS - 1) : r_row;
        w_a0        = (r_aidx == '0) ? r_acc : r_a0;
        w_we        = (r_state == S_DEC) && (r_phase == PH_CSI) && w_can_store
                      && (w_final || r_byte == CH_SEMI);
        w_dig       = {r_acc, 3'b0} + {3'b0, r_acc, 1'b0} + {12'b0, r_byte - CH_ZERO};
        w_digsat    = (w_dig > 20'd65535) ? 16'hffff : w_dig[15:0];
        // vertical moves clamp to the screen rows
        w_rsum_up = $signed({{(19-ROW_W){1'b0}}, r_row}) - $signed({3'b0, w_a0});
        w_rsum_dn = $signed({{(19-ROW_W){1'b0}}, r_row}) + $signed({3'b0, w_a0});
        w_row_up  = (w_rsum_up < 0) ? '0 :
                    (w_rsum_up > ROWS - 1) ? ROW_W'(ROWS - 1) : w_rsum_up[ROW_W-1:0];
        w_row_dn  = (w_rsum_dn > ROWS - 1) ? ROW_W'(ROWS - 1) : w_rsum_dn[ROW_W-1:0];
        w_csum_up = $signed({{(19-COL_W){1'b0}}, r_col}) + $signed({3'b0, w_a0});
        w_csum_dn = $signed({{(19-COL_W){1'b0}}, r_col}) - $signed({3'b0, w_a0});
        w_col_up  = (w_csum_up > COLS - 1) ? COL_W'(COLS - 1) : w_csum_up[COL_W-1:0];
        w_col_dn  = (w_csum_dn < 0) ? '0 : w_csum_dn[COL_W-1:0];
        w_cup_row = (r_a0 == 16'd0) ? '0 :
                    (r_a0 > 16'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(r_a0 - 16'd1);
        w_cup_col = (r_acc == 16'd0) ? '0 :
                    (r_acc > 16'(COLS)) ? COL_W'(COLS - 1) : COL_W'(r_acc - 16'd1);
        w_tab_nc  = {5'b0, r_col} + (COL_W+5)'(TAB_STEP)
                    - {5'b0, r_col % COL_W'(TAB_STEP)};
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_aidx[SLOT_W-1:0]] <= r_acc;
        end
        r_rdata <= mem[r_walk[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_mode  <= M_PLAIN;
            r_aidx  <= '0;
            r_walk  <= '0;
            r_nargs <= '0;
            r_acc   <= '0;
            r_a0    <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_dfg   <= 8'd7;
            r_dbg   <= 8'd0;
            r_fg    <= 8'd7;
            r_bg    <= 8'd0;
            r_pend  <= 1'b0;
            r_byte  <= '0;
            r_okind <= KIND_GLYPH;
            r_oglyph <= '0;
            r_orow  <= '0;
            r_ocol  <= '0;
            r_olast <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == 1'(CFG_FG)) r_dfg <= i_cfg_data;
                else r_dbg <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_byte  <= s_axis_tdata;
                        r_state <= (s_axis_tdata == 8'd0) ? S_IDLE : S_DEC;
                    end
                end
                S_DEC: begin
                    r_state <= S_IDLE;
                    if (r_phase == PH_CSI) begin
                        if (w_final) begin
                            r_phase <= PH_IDLE;
                            if (r_byte == CH_A) r_row <= w_row_up;
                            else if (r_byte == CH_B) r_row <= w_row_dn;
                            else if (r_byte == CH_C) begin
                                if (!w_at_end) r_col <= w_col_up;
                            end else if (r_byte == CH_D) begin
                                if (!w_at_end) r_col <= w_col_dn;
                            end else if (r_byte == CH_H || r_byte == CH_F) begin
                                if (r_aidx == AIDX_W'(1)) begin
                                    r_row <= w_cup_row;
                                    r_col <= w_cup_col;
                                end
                            end else if (r_byte == CH_J) begin
                                if (w_a0 == 16'd2) begin
                                    r_row    <= '0;
                                    r_col    <= '0;
                                    r_okind  <= KIND_CLEAR;
                                    r_oglyph <= '0;
                                    r_orow   <= '0;
                                    r_ocol   <= '0;
                                    r_olast  <= 1'b1;
                                    r_pend   <= 1'b0;
                                    r_state  <= S_EMIT;
                                end
                            end else if (r_byte == CH_M) begin
                                r_walk  <= '0;
                                r_mode  <= M_PLAIN;
                                r_nargs <= w_can_store ? r_aidx + AIDX_W'(1)
                                                       : AIDX_W'(ARG_SLOTS);
                                r_state <= S_SGR_RD;
                            end
                        end else if (w_can_store) begin
                            if (r_byte >= CH_ZERO && r_byte <= CH_NINE) begin
                                r_acc <= w_digsat;
                            end else if (r_byte == CH_SEMI) begin
                                if (r_aidx == '0) r_a0 <= r_acc;
                                r_aidx <= r_aidx + AIDX_W'(1);
                                r_acc  <= '0;
                            end
                        end
                    end else if (r_phase == PH_IDLE && r_byte == CH_ESC) begin
                        r_phase <= PH_ESC;
                    end else if ((r_phase == PH_IDLE && r_byte == CH_CSI) ||
                                 (r_phase == PH_ESC && r_byte == CH_LBRK)) begin
                        r_phase <= PH_CSI;
                        r_aidx  <= '0;
                        r_acc   <= '0;
                    end else begin
                        // plain text, also the byte after a lone esc
                        r_phase <= PH_IDLE;
                        if (r_byte == CH_LF) begin
                            if (r_col != '0) begin
                                r_row <= r_row + ROW_W'(1);
                                r_col <= '0;
                            end
                        end else if (r_byte == CH_CR) begin
                            r_col <= '0;
                        end else if (r_byte == CH_TAB) begin
                            if (w_tab_nc >= (COL_W+5)'(COLS)) begin
                                r_row <= w_row_base + ROW_W'(1);
                                r_col <= '0;
                            end else begin
                                r_row <= w_row_base;
                                r_col <= w_tab_nc[COL_W-1:0];
                            end
                            if (w_at_end) begin
                                r_okind  <= KIND_SCROLL;
                                r_oglyph <= '0;
                                r_orow   <= '0;
                                r_ocol   <= '0;
                                r_olast  <= 1'b1;
                                r_pend   <= 1'b0;
                                r_state  <= S_EMIT;
                            end
                        end else begin
                            r_state <= S_EMIT;
                            if (w_at_end) begin
                                r_row    <= ROW_W'(ROWS - 1);
                                r_okind  <= KIND_SCROLL;
                                r_oglyph <= '0;
                                r_orow   <= '0;
                                r_ocol   <= '0;
                                r_olast  <= 1'b0;
                                r_pend   <= 1'b1;
                            end else begin
                                r_okind  <= KIND_GLYPH;
                                r_oglyph <= r_byte;
                                r_orow   <= 5'(r_row);
                                r_ocol   <= 6'(r_col);
                                r_olast  <= 1'b1;
                                r_pend   <= 1'b0;
                                if (r_col == COL_W'(COLS - 1)) begin
                                    r_row <= r_row + ROW_W'(1);
                                    r_col <= '0;
                                end else begin
                                    r_col <= r_col + COL_W'(1);
                                end
                            end
                        end
                    end
                end
                S_SGR_RD: begin
                    r_state <= S_SGR_AP;
                end
                S_SGR_AP: begin
                    r_state <= S_SGR_RD;
                    r_walk  <= r_walk + AIDX_W'(1);
                    if (r_walk + AIDX_W'(1) == r_nargs) r_state <= S_IDLE;
                    case (r_mode)
                        M_PLAIN: begin
                            if (r_rdata == 16'd0) begin
                                r_fg <= r_dfg;
                                r_bg <= r_dbg;
                            end else if (r_rdata == 16'd1) begin
                                if (r_fg <= 8'd7) r_fg <= r_fg + 8'd8;
                            end else if (r_rdata == 16'd7) begin
                                r_fg <= r_bg;
                                r_bg <= r_fg;
                            end else if (r_rdata == 16'd38) r_mode <= M_FG;
                            else if (r_rdata == 16'd39) r_fg <= r_dfg;
                            else if (r_rdata == 16'd48) r_mode <= M_BG;
                            else if (r_rdata == 16'd49) r_bg <= r_dbg;
                            else if (r_rdata >= 16'd30 && r_rdata <= 16'd37)
                                r_fg <= 8'(r_rdata - 16'd30);
                            else if (r_rdata >= 16'd40 && r_rdata <= 16'd47)
                                r_bg <= 8'(r_rdata - 16'd40);
                        end
                        M_FG, M_BG: begin
                            if (r_rdata != 16'd5) r_state <= S_IDLE;
                            r_mode <= (r_mode == M_FG) ? M_FG5 : M_BG5;
                        end
                        M_FG5: begin
                            r_fg   <= r_rdata[7:0];
                            r_mode <= M_PLAIN;
                        end
                        M_BG5: begin
                            r_bg   <= r_rdata[7:0];
                            r_mode <= M_PLAIN;
                        end
                        default: r_mode <= M_PLAIN;
                    endcase
                end
                S_EMIT: begin
                    if (m_axis_tready) begin
                        if (r_pend) begin
                            // glyph that follows a scroll
                            r_pend   <= 1'b0;
                            r_okind  <= KIND_GLYPH;
                            r_oglyph <= r_byte;
                            r_orow   <= 5'(r_row);
                            r_ocol   <= 6'(r_col);
                            r_olast  <= 1'b1;
                            if (r_col == COL_W'(COLS - 1)) begin
                                r_row <= r_row + ROW_W'(1);
                                r_col <= '0;
                            end else begin
                                r_col <= r_col + COL_W'(1);
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_HOLDS(a_ready_no_out, !(s_axis_tready && m_axis_tvalid), "ready while result shown")
    `ASSERT_HOLDS(a_row_range, r_row <= ROW_W'(ROWS), "cursor row out of range")
    `ASSERT_HOLDS(a_glyph_row, !(m_axis_tvalid && m_axis_tuser == KIND_GLYPH) || m_axis_tdata[12:8] < 5'(ROWS), "glyph row off screen")
    `ASSERT_NEXT(a_busy_after, s_axis_tvalid && s_axis_tready && s_axis_tdata != 8'd0, !s_axis_tready, "ready right after a byte")
endmodule
